FILE: rtl/core/biquad_df2t_filter_assert.svh
// Assertion macros shared by the biquad filter RTL.
// Included by the files that check their own logic; needs nothing else.
`ifndef BIQUAD_DF2T_FILTER_ASSERT_SVH
`define BIQUAD_DF2T_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bqd_pkg.sv
// Shared types and constants of the biquad filter: sequencer states,
// control bundles and register indexes. Depends on nothing.
package bqd_pkg;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_RND_X,
      ST_SUM_Y,
      ST_LOAD_Y,
      ST_MUL_Y,
      ST_RND_Y,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic step;
      logic last;
      logic round;
   } mul_ctrl_type;

   typedef struct packed {
      logic         load_x;
      logic         load_y;
      logic         sum_y;
      logic         update;
      mul_ctrl_type mul;
   } ctrl_type;

endpackage

FILE: rtl/core/bqd_serial_mult.sv
// Bit-serial signed multiplier lane: one coefficient bit per cycle on mul.step,
// LSB first, with the product rounded to sample fraction bits. Uses bqd_pkg.
module bqd_serial_mult #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24
) (
   input  logic                      clock,
   input  logic                      load,
   input  bqd_pkg::mul_ctrl_type     mul,
   input  logic [COEF_BITS-1:0]      coef_in,
   input  logic [SAMPLE_BITS-1:0]    opnd_in,
   output logic [SAMPLE_BITS+4:0]    rnd_out
);

   localparam int S  = SAMPLE_BITS;
   localparam int C  = COEF_BITS;
   localparam int CF = COEF_BITS - 4;
   localparam int RW = SAMPLE_BITS + 5;

   logic [C-1:0]  coef_ff, coef_in_d;
   logic [S-1:0]  opnd_ff;
   logic [S:0]    acc_ff, acc_in;
   logic [C-1:0]  lo_ff, lo_in;
   logic [RW-1:0] rnd_ff;
   logic [S:0]    op_ext, addend, sum;

   assign op_ext = {opnd_ff[S-1], opnd_ff};

   // The coefficient's top bit carries negative weight, so it subtracts.
   always_comb begin
      if (!coef_ff[0]) begin
         addend = '0;
      end else if (mul.last) begin
         addend = (~op_ext) + {{S{1'b0}}, 1'b1};
      end else begin
         addend = op_ext;
      end
      sum       = acc_ff + addend;
      acc_in    = {sum[S], sum[S:1]};
      lo_in     = {sum[0], lo_ff[C-1:1]};
      coef_in_d = {1'b0, coef_ff[C-1:1]};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         coef_ff <= coef_in;
         opnd_ff <= opnd_in;
         acc_ff  <= '0;
      end else if (mul.step) begin
         coef_ff <= coef_in_d;
         acc_ff  <= acc_in;
         lo_ff   <= lo_in;
      end
      // Round half up: the dropped bit just below the kept LSB is added back.
      if (mul.round) begin
         rnd_ff <= {acc_ff, lo_ff[C-1:CF]} + {{(RW-1){1'b0}}, lo_ff[CF-1]};
      end
   end

   assign rnd_out = rnd_ff;

endmodule

FILE: rtl/core/bqd_ctrl.sv
// Sequencer of the biquad filter: walks one sample through the feedforward
// pass, the output sum, the feedback pass and the state update. Uses bqd_pkg.
`include "biquad_df2t_filter_assert.svh"

module bqd_ctrl #(
   parameter int COEF_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   output logic              req_stall,
   output bqd_pkg::ctrl_type ctrl
);

   localparam int CW = $clog2(COEF_BITS);

   bqd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               in_mul, cnt_last;

   assign in_mul   = (state_ff == bqd_pkg::ST_MUL_X) || (state_ff == bqd_pkg::ST_MUL_Y);
   assign cnt_last = (cnt_ff == CW'(COEF_BITS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqd_pkg::ST_IDLE:   if (req_valid) state_in = bqd_pkg::ST_MUL_X;
         bqd_pkg::ST_MUL_X:  if (cnt_last) state_in = bqd_pkg::ST_RND_X;
         bqd_pkg::ST_RND_X:  state_in = bqd_pkg::ST_SUM_Y;
         bqd_pkg::ST_SUM_Y:  state_in = bqd_pkg::ST_LOAD_Y;
         bqd_pkg::ST_LOAD_Y: state_in = bqd_pkg::ST_MUL_Y;
         bqd_pkg::ST_MUL_Y:  if (cnt_last) state_in = bqd_pkg::ST_RND_Y;
         bqd_pkg::ST_RND_Y:  state_in = bqd_pkg::ST_UPDATE;
         bqd_pkg::ST_UPDATE: if (out_free) state_in = bqd_pkg::ST_IDLE;
         default:            state_in = bqd_pkg::ST_IDLE;
      endcase
      cnt_in = in_mul ? cnt_ff + CW'(1) : '0;
   end

   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      case (state_ff)
         bqd_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.load_x = req_valid;
         end
         bqd_pkg::ST_MUL_X, bqd_pkg::ST_MUL_Y: begin
            ctrl.mul.step = 1'b1;
            ctrl.mul.last = cnt_last;
         end
         bqd_pkg::ST_RND_X, bqd_pkg::ST_RND_Y: ctrl.mul.round = 1'b1;
         bqd_pkg::ST_SUM_Y:  ctrl.sum_y  = 1'b1;
         bqd_pkg::ST_LOAD_Y: ctrl.load_y = 1'b1;
         bqd_pkg::ST_UPDATE: ctrl.update = out_free;
         default:            req_stall   = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `BQD_ASSERT_NEXT(a_load_starts_mul, clock, reset, ctrl.load_x, ctrl.mul.step, "multiply did not start after a sample was taken")
   `BQD_ASSERT_NEXT(a_last_then_round, clock, reset, ctrl.mul.last, ctrl.mul.round, "rounding did not follow the last multiply step")
   `BQD_ASSERT_NEXT(a_update_then_idle, clock, reset, ctrl.update, !req_stall, "sequencer did not return to idle after the update")

endmodule

FILE: rtl/core/biquad_df2t_filter.sv
// Top level of the biquad filter: coefficient registers, filter states,
// sums with saturation and the output register. Uses bqd_pkg, bqd_ctrl, bqd_serial_mult.
`include "biquad_df2t_filter_assert.svh"

// Second-order IIR filter in transposed direct form II. Each accepted sample
// yields one output beat. Three bit-serial multipliers take one coefficient
// bit per cycle: a feedforward pass forms b0*x, b1*x and b2*x, then a feedback
// pass forms a1*y and a2*y; a new sample is taken only after the last one's
// state update. A finished output waits in its own register, and a new
// sample may be accepted while it is still stalled. Coefficients must be
// written through the csr_ port only while the filter is idle; the block does
// not enforce this. Setting req_clear_history zeroes both filter states
// before that sample is processed.
module biquad_df2t_filter #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   input  logic                               req_clear_history,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                               rsp_clipped,
   input  logic                               csr_wr_en,
   input  logic [bqd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]               csr_wr_data
);

   localparam int S  = SAMPLE_BITS;
   localparam int C  = COEF_BITS;
   localparam int CF = COEF_BITS - 4;
   localparam int T  = SAMPLE_BITS + 8;
   localparam int RW = SAMPLE_BITS + 5;
   localparam logic [C-1:0] B0_RESET = {3'b000, 1'b1, {CF{1'b0}}};

   bqd_pkg::ctrl_type ctrl;

   logic [C-1:0]    b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [T-1:0]    d1_ff, d2_ff, n1, n2;
   logic [S-1:0]    y_ff, y_sat;
   logic            clip_ff, clip_y, clip_n1;
   logic [S+8:0]    t1_ff, y_sum;
   logic [RW-1:0]   r2_ff, rnd0, rnd1, rnd2;
   logic [S+9:0]    n1_sum;
   logic [S+5:0]    n2_sum;
   logic            rsp_valid_ff;
   logic [S-1:0]    rsp_sample_ff;
   logic            rsp_clipped_ff;
   logic            out_free, accept;
   logic [C-1:0]    coef1_sel, coef2_sel;
   logic [S-1:0]    opnd_sel;
   logic            load_yx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   bqd_ctrl #(.COEF_BITS(C)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   // Lanes 1 and 2 serve the feedforward pass first and the feedback pass after.
   assign load_yx   = ctrl.load_x || ctrl.load_y;
   assign coef1_sel = ctrl.load_y ? a1_ff : b1_ff;
   assign coef2_sel = ctrl.load_y ? a2_ff : b2_ff;
   assign opnd_sel  = ctrl.load_y ? y_ff : req_sample_in;

   bqd_serial_mult #(.SAMPLE_BITS(S), .COEF_BITS(C)) u_lane0 (
      .clock   (clock),
      .load    (ctrl.load_x),
      .mul     (ctrl.mul),
      .coef_in (b0_ff),
      .opnd_in (req_sample_in),
      .rnd_out (rnd0)
   );

   bqd_serial_mult #(.SAMPLE_BITS(S), .COEF_BITS(C)) u_lane1 (
      .clock   (clock),
      .load    (load_yx),
      .mul     (ctrl.mul),
      .coef_in (coef1_sel),
      .opnd_in (opnd_sel),
      .rnd_out (rnd1)
   );

   bqd_serial_mult #(.SAMPLE_BITS(S), .COEF_BITS(C)) u_lane2 (
      .clock   (clock),
      .load    (load_yx),
      .mul     (ctrl.mul),
      .coef_in (coef2_sel),
      .opnd_in (opnd_sel),
      .rnd_out (rnd2)
   );

   always_comb begin
      y_sum = {{4{rnd0[RW-1]}}, rnd0} + {d1_ff[T-1], d1_ff};
      if ((&y_sum[S+8:S-1]) || !(|y_sum[S+8:S-1])) begin
         y_sat  = y_sum[S-1:0];
         clip_y = 1'b0;
      end else begin
         y_sat  = {y_sum[S+8], {(S-1){~y_sum[S+8]}}};
         clip_y = 1'b1;
      end

      n1_sum = {t1_ff[S+8], t1_ff} - {{5{rnd1[RW-1]}}, rnd1};
      if ((&n1_sum[S+9:T-1]) || !(|n1_sum[S+9:T-1])) begin
         n1      = n1_sum[T-1:0];
         clip_n1 = 1'b0;
      end else begin
         n1      = {n1_sum[S+9], {(T-1){~n1_sum[S+9]}}};
         clip_n1 = 1'b1;
      end

      // The difference of two rounded products always fits the state range.
      n2_sum = {r2_ff[RW-1], r2_ff} - {rnd2[RW-1], rnd2};
      n2     = {{2{n2_sum[S+5]}}, n2_sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bqd_pkg::CSR_COEF_B0: b0_ff <= csr_wr_data;
            bqd_pkg::CSR_COEF_B1: b1_ff <= csr_wr_data;
            bqd_pkg::CSR_COEF_B2: b2_ff <= csr_wr_data;
            bqd_pkg::CSR_COEF_A1: a1_ff <= csr_wr_data;
            bqd_pkg::CSR_COEF_A2: a2_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (accept && req_clear_history) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctrl.update) begin
         d1_ff <= n1;
         d2_ff <= n2;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_y) begin
         y_ff    <= y_sat;
         clip_ff <= clip_y;
         t1_ff   <= {{4{rnd1[RW-1]}}, rnd1} + {d2_ff[T-1], d2_ff};
         r2_ff   <= rnd2;
      end
      if (ctrl.update) begin
         rsp_sample_ff  <= y_ff;
         rsp_clipped_ff <= clip_ff || clip_n1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   `BQD_ASSERT_NEXT(a_update_fills_output, clock, reset, ctrl.update, rsp_valid_ff, "output register not filled after a state update")
   `BQD_ASSERT_NOW(a_update_needs_room, clock, reset, ctrl.update, out_free, "state update while the output register is still held")
   `BQD_ASSERT_NEXT(a_clear_zeroes_states, clock, reset, accept && req_clear_history, (d1_ff == '0) && (d2_ff == '0), "history clear did not zero the filter states")

endmodule
